/* hw/rtl/pfa_pkg.sv */
// Shared types and constants for the per-CPU page free-list allocator.
`default_nettype none

package pfa_pkg;

	localparam int ADDR_W        = 32;
	localparam int PAGE_SHIFT    = 12;
	localparam int CPU_FIELD_W   = 3;
	localparam int CFG_IDX_W     = 2;
	localparam int NUM_CPUS_DEF  = 8;
	localparam int NUM_PAGES_DEF = 32768;

	localparam logic [ADDR_W-1:0] REGION_BASE_RST = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] LOW_LIMIT_RST   = 32'h8002_0000;
	localparam logic [ADDR_W-1:0] HIGH_LIMIT_RST  = 32'h8800_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REGION_BASE = 2'd0,
		CFG_LOW_LIMIT   = 2'd1,
		CFG_HIGH_LIMIT  = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK_LO,
		ST_CHK_HI,
		ST_CHK_BASE,
		ST_PUSH,
		ST_POP_TRY,
		ST_SCAN,
		ST_POP_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		alu_op_t           op;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] sum;
		logic              carry;
	} alu_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/pfa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pfa_alu.sv */
// Shared 32-bit add/subtract unit used for range checks and address forming.
`default_nettype none

module pfa_alu (
	input  wire pfa_pkg::alu_req_t req,
	output      pfa_pkg::alu_rsp_t rsp
);

	logic [pfa_pkg::ADDR_W:0] total;

	always_comb begin
		if (req.op == pfa_pkg::ALU_SUB) begin
			// carry out high means a >= b
			total = {1'b0, req.a} + {1'b0, ~req.b} + (pfa_pkg::ADDR_W + 1)'(1);
		end else begin
			total = {1'b0, req.a} + {1'b0, req.b};
		end
		rsp.sum   = total[pfa_pkg::ADDR_W-1:0];
		rsp.carry = total[pfa_pkg::ADDR_W];
	end

endmodule

`default_nettype wire

/* hw/rtl/per_cpu_page_free_list_allocator.sv */
// Top level: per-CPU LIFO page free lists with stealing, under a small sequencer.
//
// Channel   Dir  Handshake              Word
// req       in   req_valid/req_ready    opcode, cpu, page_address
// rsp       out  rsp_valid/rsp_ready    granted, result_address, fault
// cfg       in   cfg_we                 cfg_index, cfg_data
//
// One request at a time. A free steps through the low, high and base checks on the shared
// adder (the base check also forms the page index), the push and the result load. An allocate
// from a non-empty own list steps through head look-up with link read, head update with the
// address add and result load; stealing adds a scan step for each list scanned. The next word
// is taken in the idle state after the result load. A waiting result stalls only the finish of
// the next request. Reset empties all lists at once.
`default_nettype none

module per_cpu_page_free_list_allocator #(
	parameter int NUM_CPUS  = pfa_pkg::NUM_CPUS_DEF,
	parameter int NUM_PAGES = pfa_pkg::NUM_PAGES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output      logic                              req_ready,
	input  wire logic                              opcode,
	input  wire logic [pfa_pkg::CPU_FIELD_W-1:0]   cpu,
	input  wire logic [pfa_pkg::ADDR_W-1:0]        page_address,
	output      logic                              rsp_valid,
	input  wire logic                              rsp_ready,
	output      logic                              granted,
	output      logic [pfa_pkg::ADDR_W-1:0]        result_address,
	output      logic                              fault,
	input  wire logic                              cfg_we,
	input  wire logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pfa_pkg::ADDR_W-1:0]        cfg_data
);

	localparam int IDX_W  = $clog2(NUM_PAGES);
	localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int PFN_W  = pfa_pkg::ADDR_W - pfa_pkg::PAGE_SHIFT;
	localparam logic [CPU_W-1:0] LAST_CPU = CPU_W'(NUM_CPUS - 1);

	pfa_pkg::state_t state_q, state_d;

	logic [pfa_pkg::ADDR_W-1:0] region_base_q, low_limit_q, high_limit_q;

	logic [NUM_CPUS-1:0] head_vld_q;
	logic [IDX_W-1:0]    head_idx_q [NUM_CPUS];

	logic [pfa_pkg::ADDR_W-1:0] addr_q;
	logic [CPU_W-1:0]           sel_q;
	logic [IDX_W-1:0]           page_q;
	logic                       bad_q;
	logic                       got_q;
	logic [pfa_pkg::ADDR_W-1:0] sum_q;

	logic                       rsp_valid_q;
	logic                       granted_q;
	logic [pfa_pkg::ADDR_W-1:0] result_q;
	logic                       fault_q;

	pfa_pkg::alu_req_t alu_req;
	pfa_pkg::alu_rsp_t alu_rsp;

	logic             ram_we, ram_re;
	logic [IDX_W:0]   ram_wdata, ram_rdata;

	logic cpu_ok, head_hit, rsp_free, idx_over;

	assign cpu_ok   = {{(32 - pfa_pkg::CPU_FIELD_W){1'b0}}, cpu} < 32'(NUM_CPUS);
	assign head_hit = head_vld_q[sel_q];
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign idx_over = {1'b0, alu_rsp.sum[pfa_pkg::ADDR_W-1:pfa_pkg::PAGE_SHIFT]}
	                  >= (PFN_W + 1)'(NUM_PAGES);

	assign ram_wdata = {head_vld_q[sel_q], head_idx_q[sel_q]};

	pfa_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	pfa_ram #(
		.WIDTH (IDX_W + 1),
		.DEPTH (NUM_PAGES)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (page_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_idx_q[sel_q]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		alu_req.op = pfa_pkg::ALU_SUB;
		alu_req.a  = addr_q;
		alu_req.b  = low_limit_q;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		unique case (state_q)
			pfa_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (pfa_pkg::opcode_t'(opcode) == pfa_pkg::OP_FREE) begin
						state_d = pfa_pkg::ST_CHK_LO;
					end else if (cpu_ok) begin
						state_d = pfa_pkg::ST_POP_TRY;
					end else begin
						state_d = pfa_pkg::ST_SCAN;
					end
				end
			end
			pfa_pkg::ST_CHK_LO: begin
				state_d = pfa_pkg::ST_CHK_HI;
			end
			pfa_pkg::ST_CHK_HI: begin
				alu_req.b = high_limit_q;
				state_d   = pfa_pkg::ST_CHK_BASE;
			end
			pfa_pkg::ST_CHK_BASE: begin
				alu_req.b = region_base_q;
				state_d   = pfa_pkg::ST_PUSH;
			end
			pfa_pkg::ST_PUSH: begin
				ram_we  = !bad_q;
				state_d = pfa_pkg::ST_FINISH;
			end
			pfa_pkg::ST_POP_TRY: begin
				ram_re  = head_hit;
				state_d = head_hit ? pfa_pkg::ST_POP_WAIT : pfa_pkg::ST_SCAN;
			end
			pfa_pkg::ST_SCAN: begin
				ram_re = head_hit;
				if (head_hit) begin
					state_d = pfa_pkg::ST_POP_WAIT;
				end else if (sel_q == LAST_CPU) begin
					state_d = pfa_pkg::ST_FINISH;
				end
			end
			pfa_pkg::ST_POP_WAIT: begin
				alu_req.op = pfa_pkg::ALU_ADD;
				alu_req.a  = region_base_q;
				alu_req.b  = {PFN_W'(page_q), {pfa_pkg::PAGE_SHIFT{1'b0}}};
				state_d    = pfa_pkg::ST_FINISH;
			end
			pfa_pkg::ST_FINISH: begin
				if (rsp_free) begin
					state_d = pfa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfa_pkg::ST_IDLE;
			end
		endcase
	end

	// control state: config registers, list valid bits, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= pfa_pkg::REGION_BASE_RST;
			low_limit_q   <= pfa_pkg::LOW_LIMIT_RST;
			high_limit_q  <= pfa_pkg::HIGH_LIMIT_RST;
			head_vld_q    <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (pfa_pkg::cfg_reg_t'(cfg_index))
					pfa_pkg::CFG_REGION_BASE: region_base_q <= cfg_data;
					pfa_pkg::CFG_LOW_LIMIT:   low_limit_q   <= cfg_data;
					pfa_pkg::CFG_HIGH_LIMIT:  high_limit_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == pfa_pkg::ST_PUSH && !bad_q) begin
				head_vld_q[sel_q] <= 1'b1;
			end else if (state_q == pfa_pkg::ST_POP_WAIT) begin
				head_vld_q[sel_q] <= ram_rdata[IDX_W];
			end
			if (state_q == pfa_pkg::ST_FINISH && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pfa_pkg::ST_IDLE: begin
				if (req_valid) begin
					addr_q <= page_address;
					sel_q  <= cpu_ok ? CPU_W'(cpu) : '0;
					bad_q  <= (pfa_pkg::opcode_t'(opcode) == pfa_pkg::OP_FREE) && !cpu_ok;
					got_q  <= 1'b0;
				end
			end
			pfa_pkg::ST_CHK_LO: begin
				bad_q <= bad_q || (addr_q[pfa_pkg::PAGE_SHIFT-1:0] != '0) || !alu_rsp.carry;
			end
			pfa_pkg::ST_CHK_HI: begin
				bad_q <= bad_q || alu_rsp.carry;
			end
			pfa_pkg::ST_CHK_BASE: begin
				bad_q  <= bad_q || !alu_rsp.carry || idx_over;
				page_q <= alu_rsp.sum[pfa_pkg::PAGE_SHIFT +: IDX_W];
			end
			pfa_pkg::ST_PUSH: begin
				if (!bad_q) begin
					head_idx_q[sel_q] <= page_q;
				end
			end
			pfa_pkg::ST_POP_TRY: begin
				if (head_hit) begin
					page_q <= head_idx_q[sel_q];
					got_q  <= 1'b1;
				end else begin
					sel_q <= '0;
				end
			end
			pfa_pkg::ST_SCAN: begin
				if (head_hit) begin
					page_q <= head_idx_q[sel_q];
					got_q  <= 1'b1;
				end else if (sel_q != LAST_CPU) begin
					sel_q <= sel_q + CPU_W'(1);
				end
			end
			pfa_pkg::ST_POP_WAIT: begin
				head_idx_q[sel_q] <= ram_rdata[IDX_W-1:0];
				sum_q             <= alu_rsp.sum;
			end
			pfa_pkg::ST_FINISH: begin
				if (rsp_free) begin
					granted_q <= got_q;
					result_q  <= got_q ? sum_q : '0;
					fault_q   <= bad_q;
				end
			end
			default: ;
		endcase
	end

	assign req_ready      = (state_q == pfa_pkg::ST_IDLE);
	assign rsp_valid      = rsp_valid_q;
	assign granted        = granted_q;
	assign result_address = result_q;
	assign fault          = fault_q;

endmodule

`default_nettype wire

/* test/tb_per_cpu_page_free_list_allocator.sv */
// Self-checking bench for the per-CPU page allocator: directed words, then random traffic, then a double free.
module tb_per_cpu_page_free_list_allocator;

	localparam int ADDR_W       = pfa_pkg::ADDR_W;
	localparam int PAGE_SHIFT   = pfa_pkg::PAGE_SHIFT;
	localparam int CFG_IDX_W    = pfa_pkg::CFG_IDX_W;
	localparam int CPU_FIELD_W  = pfa_pkg::CPU_FIELD_W;
	localparam int CPUS         = pfa_pkg::NUM_CPUS_DEF;
	localparam int PAGES        = pfa_pkg::NUM_PAGES_DEF;
	localparam int IDX_W        = $clog2(PAGES);
	localparam int PHASE_ITEMS  = 135;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT  = 1000;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic              granted;
		logic [ADDR_W-1:0] addr;
		logic              fault;
	} page_reply_t;

	typedef struct packed {
		bit             live;
		bit [IDX_W-1:0] idx;
	} page_link_t;

	// on a reprogram row, addr carries the region base
	typedef struct packed {
		bit                cfg;
		pfa_pkg::opcode_t  op;
		logic [2:0]        cpu;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		bit                typed;
		page_reply_t       want;
	} row_t;

	localparam page_reply_t NO_PAGE  = '{1'b0, 32'h0, 1'b0};
	localparam page_reply_t REJECTED = '{1'b0, 32'h0, 1'b1};

	localparam row_t ROWS [29] = '{
		'{1'b0, pfa_pkg::OP_ALLOC, 3'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, NO_PAGE},
		'{1'b0, pfa_pkg::OP_FREE,  3'd7, 32'h8002_0000, 32'h0, 32'h0, 1'b1, NO_PAGE},
		'{1'b0, pfa_pkg::OP_FREE,  3'd7, 32'h87FF_F000, 32'h0, 32'h0, 1'b1, NO_PAGE},
		'{1'b0, pfa_pkg::OP_FREE,  3'd3, 32'h8001_F000, 32'h0, 32'h0, 1'b1, REJECTED},
		'{1'b0, pfa_pkg::OP_FREE,  3'd3, 32'h8800_0000, 32'h0, 32'h0, 1'b1, REJECTED},
		'{1'b0, pfa_pkg::OP_FREE,  3'd3, 32'h8002_0800, 32'h0, 32'h0, 1'b1, REJECTED},
		'{1'b0, pfa_pkg::OP_FREE,  3'd3, 32'h8002_0001, 32'h0, 32'h0, 1'b1, REJECTED},
		'{1'b0, pfa_pkg::OP_FREE,  3'd3, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, REJECTED},
		'{1'b0, pfa_pkg::OP_FREE,  3'd3, 32'h0000_0000, 32'h0, 32'h0, 1'b1, REJECTED},
		'{1'b0, pfa_pkg::OP_ALLOC, 3'd7, 32'h0000_0000, 32'h0, 32'h0, 1'b1,
			'{1'b1, 32'h87FF_F000, 1'b0}},
		// own list empty: steal from CPU 7
		'{1'b0, pfa_pkg::OP_ALLOC, 3'd2, 32'h1234_5678, 32'h0, 32'h0, 1'b1,
			'{1'b1, 32'h8002_0000, 1'b0}},
		'{1'b0, pfa_pkg::OP_ALLOC, 3'd5, 32'h5555_5555, 32'h0, 32'h0, 1'b1, NO_PAGE},
		'{1'b0, pfa_pkg::OP_FREE,  3'd1, 32'h8002_1000, 32'h0, 32'h0, 1'b0, NO_PAGE},
		'{1'b0, pfa_pkg::OP_FREE,  3'd4, 32'h8002_2000, 32'h0, 32'h0, 1'b0, NO_PAGE},
		'{1'b0, pfa_pkg::OP_FREE,  3'd4, 32'h8002_3000, 32'h0, 32'h0, 1'b0, NO_PAGE},
		'{1'b0, pfa_pkg::OP_ALLOC, 3'd0, 32'hAAAA_AAAA, 32'h0, 32'h0, 1'b0, NO_PAGE},
		'{1'b0, pfa_pkg::OP_ALLOC, 3'd4, 32'h0000_0000, 32'h0, 32'h0, 1'b0, NO_PAGE},
		'{1'b1, pfa_pkg::OP_ALLOC, 3'd0, 32'h0000_0000, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_PAGE},
		'{1'b0, pfa_pkg::OP_FREE,  3'd6, 32'h0000_0000, 32'h0, 32'h0, 1'b1, NO_PAGE},
		'{1'b0, pfa_pkg::OP_FREE,  3'd6, 32'h07FF_F000, 32'h0, 32'h0, 1'b1, NO_PAGE},
		// one page past the end of the link memory
		'{1'b0, pfa_pkg::OP_FREE,  3'd6, 32'h0800_0000, 32'h0, 32'h0, 1'b1, REJECTED},
		'{1'b1, pfa_pkg::OP_ALLOC, 3'd0, 32'hFFFF_F000, 32'h0, 32'hFFFF_FFFF, 1'b0, NO_PAGE},
		// top page under the new base wraps past 2^32
		'{1'b0, pfa_pkg::OP_ALLOC, 3'd6, 32'h0000_0000, 32'h0, 32'h0, 1'b0, NO_PAGE},
		'{1'b0, pfa_pkg::OP_FREE,  3'd2, 32'h0000_0000, 32'h0, 32'h0, 1'b1, REJECTED},
		'{1'b0, pfa_pkg::OP_FREE,  3'd2, 32'hFFFF_F000, 32'h0, 32'h0, 1'b1, NO_PAGE},
		'{1'b0, pfa_pkg::OP_ALLOC, 3'd2, 32'h0000_0000, 32'h0, 32'h0, 1'b1,
			'{1'b1, 32'hFFFF_F000, 1'b0}},
		'{1'b0, pfa_pkg::OP_ALLOC, 3'd6, 32'h0000_0000, 32'h0, 32'h0, 1'b0, NO_PAGE},
		'{1'b1, pfa_pkg::OP_ALLOC, 3'd0, 32'h8000_0000, 32'h0, 32'h0, 1'b0, NO_PAGE},
		'{1'b0, pfa_pkg::OP_FREE,  3'd0, 32'h8000_0000, 32'h0, 32'h0, 1'b1, REJECTED}
	};

	localparam logic [ADDR_W-1:0] PHASE_BASE [4] =
		'{pfa_pkg::REGION_BASE_RST, 32'h0000_0000, 32'hC000_0000, 32'hFFF8_0000};
	localparam logic [ADDR_W-1:0] PHASE_FLOOR [4] =
		'{pfa_pkg::LOW_LIMIT_RST, 32'h0000_1000, 32'hC000_0000, 32'hFFF8_0000};
	localparam logic [ADDR_W-1:0] PHASE_CEIL [4] =
		'{pfa_pkg::HIGH_LIMIT_RST, 32'h0800_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	logic                 opcode = 1'b0;
	logic [CPU_FIELD_W-1:0] cpu = '0;
	logic [ADDR_W-1:0]    page_address = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	logic                 granted;
	logic [ADDR_W-1:0]    result_address;
	logic                 fault;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data = '0;

	// allocator state as the bench sees it
	logic [ADDR_W-1:0] base_reg = pfa_pkg::REGION_BASE_RST;
	logic [ADDR_W-1:0] floor_reg = pfa_pkg::LOW_LIMIT_RST;
	logic [ADDR_W-1:0] ceiling_reg = pfa_pkg::HIGH_LIMIT_RST;
	page_link_t        next_link [PAGES];
	page_link_t        list_top [CPUS];
	bit                on_list [PAGES];

	page_reply_t       page_replies [$];
	logic [IDX_W-1:0]  pool [40];
	bit                steady = 1'b0;
	int                mismatches = 0;
	int                quiet_cycles = 0;

	per_cpu_page_free_list_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.opcode(opcode),
		.cpu(cpu),
		.page_address(page_address),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.granted(granted),
		.result_address(result_address),
		.fault(fault),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic page_reply_t page_reply_for(input pfa_pkg::opcode_t op,
			input logic [2:0] c, input logic [ADDR_W-1:0] a);
		page_reply_t      r;
		logic [ADDR_W-1:0] off;
		logic [IDX_W-1:0] page;
		int               src;
		r = '0;
		if (op == pfa_pkg::OP_FREE) begin
			off = a - base_reg;
			if (a[PAGE_SHIFT-1:0] != '0 || a < floor_reg || a >= ceiling_reg ||
					a < base_reg || off[ADDR_W-1:PAGE_SHIFT] >= PAGES)
				r.fault = 1'b1;
			else begin
				page = off[PAGE_SHIFT +: IDX_W];
				next_link[page] = list_top[c];
				list_top[c] = '{1'b1, page};
				on_list[page] = 1'b1;
			end
		end else begin
			src = -1;
			if (list_top[c].live)
				src = c;
			for (int k = 0; k < CPUS; k++)
				if (src < 0 && list_top[k].live)
					src = k;
			if (src >= 0) begin
				page = list_top[src].idx;
				list_top[src] = next_link[page];
				on_list[page] = 1'b0;
				r.granted = 1'b1;
				r.addr = base_reg + (32'(page) << PAGE_SHIFT);
			end
		end
		return r;
	endfunction

	task automatic send_word(input pfa_pkg::opcode_t op, input logic [2:0] c,
			input logic [ADDR_W-1:0] a, input bit typed, input page_reply_t want);
		int          gap;
		page_reply_t reply;
		gap = steady ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		cpu <= c;
		page_address <= a;
		do @(posedge clk); while (!req_ready);
		reply = page_reply_for(op, c, a);
		page_replies.push_back(typed ? want : reply);
	endtask

	// drop valid and hold until every reply is back
	task automatic settle();
		req_valid <= 1'b0;
		do @(posedge clk); while (page_replies.size() != 0);
	endtask

	task automatic program_window(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] lo,
			input logic [ADDR_W-1:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= pfa_pkg::CFG_REGION_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= pfa_pkg::CFG_LOW_LIMIT;
		cfg_data <= lo;
		@(posedge clk);
		cfg_index <= pfa_pkg::CFG_HIGH_LIMIT;
		cfg_data <= hi;
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_we <= 1'b0;
		base_reg = base;
		floor_reg = lo;
		ceiling_reg = hi;
	endtask

	task automatic compare_field(input string what, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, what, want, got);
		end
	endtask

	initial begin
		int               alloc_pct;
		int               roll;
		bit               found;
		logic [IDX_W-1:0] pick;
		logic [ADDR_W-1:0] a;
		pfa_pkg::opcode_t op;
		for (int k = 0; k < 32; k++)
			pool[k] = IDX_W'(32 + k);
		for (int k = 0; k < 8; k++)
			pool[32 + k] = IDX_W'(PAGES - 8 + k);
		alloc_pct = 45;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (ROWS[r]) begin
			if (ROWS[r].cfg) begin
				settle();
				program_window(ROWS[r].addr, ROWS[r].lo, ROWS[r].hi);
			end else
				send_word(ROWS[r].op, ROWS[r].cpu, ROWS[r].addr, ROWS[r].typed, ROWS[r].want);
		end

		for (int ph = 0; ph < 4; ph++) begin
			settle();
			program_window(PHASE_BASE[ph], PHASE_FLOOR[ph], PHASE_CEIL[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// swing between filling and draining the lists
				if (n % 25 == 0) begin
					case ($urandom_range(0, 2))
						0: alloc_pct = 25;
						1: alloc_pct = 45;
						default: alloc_pct = 70;
					endcase
					steady = ($urandom_range(0, 3) == 0);
				end
				roll = $urandom_range(0, 99);
				a = $urandom;
				op = pfa_pkg::OP_ALLOC;
				if (roll >= alloc_pct && roll < 92) begin
					found = 1'b0;
					pick = '0;
					for (int t = 0; t < 8 && !found; t++) begin
						pick = pool[$urandom_range(0, 39)];
						found = !on_list[pick];
					end
					if (found) begin
						op = pfa_pkg::OP_FREE;
						a = base_reg + (32'(pick) << PAGE_SHIFT);
					end
				end else if (roll >= 92) begin
					op = pfa_pkg::OP_FREE;
					case ($urandom_range(0, 4))
						0: a = $urandom;
						1: a = base_reg + (32'(pool[$urandom_range(0, 39)]) << PAGE_SHIFT)
							+ 32'($urandom_range(1, 4095));
						2: a = floor_reg - 32'h1000;
						3: a = ceiling_reg;
						default: a = base_reg + (32'(PAGES) << PAGE_SHIFT);
					endcase
				end
				send_word(op, 3'($urandom_range(0, CPUS - 1)), a, 1'b0, NO_PAGE);
			end
		end

		// free one page twice: the list loops back on itself from here on
		steady = 1'b0;
		a = base_reg + (32'(pool[8]) << PAGE_SHIFT);
		send_word(pfa_pkg::OP_FREE, 3'd5, a, 1'b0, NO_PAGE);
		send_word(pfa_pkg::OP_FREE, 3'd5, a, 1'b0, NO_PAGE);
		repeat (3) send_word(pfa_pkg::OP_ALLOC, 3'd5, $urandom, 1'b0, NO_PAGE);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int          stall;
		page_reply_t want;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			if (page_replies.size() == 0) begin
				mismatches++;
				$display("%0t: expected no reply got granted %0b address %h fault %0b",
					$time, granted, result_address, fault);
			end else begin
				want = page_replies.pop_front();
				compare_field("granted", ADDR_W'(want.granted), ADDR_W'(granted));
				compare_field("result_address", want.addr, result_address);
				compare_field("fault", ADDR_W'(want.fault), ADDR_W'(fault));
			end
		end
	end

	// end the run if no word moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

/* sim.f */
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ram.sv
hw/rtl/pfa_alu.sv
hw/rtl/per_cpu_page_free_list_allocator.sv
test/tb_per_cpu_page_free_list_allocator.sv
